// ===== src/multi_timer_table_macros.svh =====
// assertion macros for the timer table
`ifndef MULTI_TIMER_TABLE_MACROS_SVH
`define MULTI_TIMER_TABLE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define MTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication outside reset
`define MTT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/mtt_pkg.sv =====
package mtt_pkg;
    localparam int TimerSlots = 16;
    localparam int SlotW = $clog2(TimerSlots);
    localparam int CntW = $clog2(TimerSlots + 1);
    localparam int MaxResults = 16;
    localparam int ResW = $clog2(MaxResults + 1);

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_DEL = 3'd1;
    localparam logic [2:0] MODE_RST = 3'd2;
    localparam logic [2:0] MODE_QRY = 3'd3;
    localparam logic [2:0] MODE_TICK = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DUP = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // slot record: key, periodic, notify, period, deadline
    localparam int RecW = 32 + 1 + 1 + 32 + 64;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic        present;
        logic [31:0] key;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [31:0] key;
        logic        periodic;
        logic        notify;
        logic [31:0] period;
        logic [63:0] deadline;
    } t_rec;
endpackage

// ===== src/mtt_ram.sv =====
module mtt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/mtt_outq.sv =====
module mtt_outq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  mtt_pkg::t_result       i_data,
    input  logic                   i_pop,
    output logic                   o_valid,
    output mtt_pkg::t_result       o_data,
    output logic [mtt_pkg::ResW-1:0] o_count
);
    localparam int AW = $clog2(mtt_pkg::MaxResults);
    localparam int ResW = mtt_pkg::ResW;
    mtt_pkg::t_result r_q [mtt_pkg::MaxResults];
    logic [AW-1:0] r_wp, r_rp;
    logic [mtt_pkg::ResW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (i_pop) r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + ResW'(i_push) - ResW'(i_pop);
        end
        if (i_push) r_q[r_wp] <= i_data;
    end
    assign o_valid = (r_cnt != '0);
    assign o_data = r_q[r_rp];
    assign o_count = r_cnt;
endmodule

// ===== src/multi_timer_table.sv =====
// channel | dir | tdata fields (low bit up)                       | tuser
// s_axis  | in  | timer_key, period_ticks                        | mode, periodic, notify_enable
// m_axis  | out | expired_key                                    | result_kind, status_code, present
//         |     | tlast = last_of_run                            |
// a command makes one slot read per cycle over the table, then reads back the
// matching record, and then writes and answers
// a tick marks due slots over the table, then for each expiring timer picks
// the earliest pending one and services it, and finishes once none is
// pending; the registered-read slot memory and the one shared 64-bit compare
// set these steps
// reset is synchronous, active low; it clears the used bits, time and queue
// results wait in a 16-entry queue; a new item is taken only when it is empty
`include "multi_timer_table_macros.svh"
module multi_timer_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // timer_key[31:0], period_ticks[63:32]
    input  logic [4:0]  s_axis_tuser,   // mode[2:0], periodic[3], notify_enable[4]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // expired_key[31:0]
    output logic [3:0]  m_axis_tuser,   // result_kind[0], status_code[2:1], present[3]
    output logic        m_axis_tlast    // last_of_run
);
    localparam int N = mtt_pkg::TimerSlots;
    localparam int SW = mtt_pkg::SlotW;
    localparam int CW = mtt_pkg::CntW;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,  // command: search key / free slot
        S_WRITE = 7'b0000100,  // command: update and answer
        S_MARK  = 7'b0001000,  // tick: mark due slots
        S_PICK  = 7'b0010000,  // tick: find earliest pending
        S_SERV  = 7'b0100000,  // tick: service the chosen slot
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state;
    logic [N-1:0] r_used, r_pend, r_pendn;
    logic [63:0] r_time;
    logic [2:0]  r_mode;
    logic [31:0] r_key, r_per;
    logic        r_perflag, r_notflag;
    logic [CW-1:0] r_idx;          // address issued, one ahead of data
    logic [SW-1:0] r_didx;         // slot whose data is on rdata
    logic        r_dv;
    logic        r_found, r_free_ok;
    logic [SW-1:0] r_fslot, r_freeslot;
    logic        r_best_ok;
    logic [SW-1:0] r_best;
    logic [63:0] r_best_dl;
    logic [mtt_pkg::ResW-1:0] r_nres;

    mtt_pkg::t_rec w_rd, w_wr;
    logic w_we;
    logic [SW-1:0] w_waddr, w_raddr;
    logic w_push;
    mtt_pkg::t_result w_pd, w_qd;
    logic w_qv;
    logic [mtt_pkg::ResW-1:0] w_qcnt;

    mtt_ram #(.Width(mtt_pkg::RecW), .Depth(N)) u_slots (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wr),
        .i_raddr(w_raddr), .o_rdata(w_rd)
    );

    mtt_outq u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_pd),
        .i_pop(m_axis_tvalid && m_axis_tready), .o_valid(w_qv), .o_data(w_qd),
        .o_count(w_qcnt)
    );

    assign s_axis_tready = (r_state == S_IDLE) && (w_qcnt == '0);
    assign m_axis_tvalid = w_qv;
    assign m_axis_tdata = w_qd.key;
    assign m_axis_tuser = {w_qd.present, w_qd.status, w_qd.kind};
    assign m_axis_tlast = w_qd.last;

    logic w_acc, w_scan_end;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_scan_end = r_dv && (r_didx == SW'(N - 1));

    // read address: running index; slot 0 while idle and on leaving service
    // so a new pass starts at slot 0; chosen slot on entering service; found slot in S_FIN for the rewrite
    always_comb begin
        w_raddr = r_idx[SW-1:0];
        if (r_idx >= CW'(N)) w_raddr = '0;
        if (r_state == S_IDLE) w_raddr = '0;
        else if (r_state == S_FIN) w_raddr = r_fslot;
        else if (r_state == S_SERV) w_raddr = r_dv ? '0 : r_best;
    end

    // shared 64-bit compare
    logic w_lt;
    always_comb begin
        if (r_state == S_MARK) w_lt = !(r_time < w_rd.deadline);
        else w_lt = w_rd.deadline < r_best_dl;
    end

    always_comb begin
        w_we = 1'b0;
        w_waddr = r_fslot;
        w_wr = w_rd;
        w_push = 1'b0;
        w_pd = '0;
        w_pd.last = 1'b1;
        if (r_state == S_WRITE) begin
            w_push = 1'b1;
            case (r_mode)
                mtt_pkg::MODE_ADD: begin
                    if (r_found) w_pd.status = mtt_pkg::ST_DUP;
                    else if (!r_free_ok) w_pd.status = mtt_pkg::ST_FULL;
                    else begin
                        w_we = 1'b1;
                        w_waddr = r_freeslot;
                        w_wr.key = r_key;
                        w_wr.periodic = r_perflag;
                        w_wr.notify = r_notflag;
                        w_wr.period = r_per;
                        w_wr.deadline = r_time + {32'd0, r_per};
                    end
                end
                mtt_pkg::MODE_DEL: if (!r_found) w_pd.status = mtt_pkg::ST_NOTFOUND;
                mtt_pkg::MODE_RST: begin
                    // periodic and notify bits come back from the found record
                    if (!r_found) w_pd.status = mtt_pkg::ST_NOTFOUND;
                    else begin
                        w_we = 1'b1;
                        w_wr.period = r_per;
                        w_wr.deadline = r_time + {32'd0, r_per};
                    end
                end
                default: w_pd.present = r_found;
            endcase
        end else if (r_state == S_SERV && r_dv) begin
            w_waddr = r_best;
            w_we = w_rd.periodic;
            w_wr.deadline = r_time + {32'd0, w_rd.period};
            if (w_rd.notify && r_nres < mtt_pkg::ResW'(mtt_pkg::MaxResults)) begin
                w_push = 1'b1;
                w_pd.kind = 1'b1;
                w_pd.key = w_rd.key;
                // last when no other notifying timer is still pending, or at the MaxResults-th result of the run
                w_pd.last = ((r_pendn & ~(N'(1) << r_best)) == '0) ||
                    (r_nres == mtt_pkg::ResW'(mtt_pkg::MaxResults - 1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_time <= '0;
            r_dv <= 1'b0;
            r_idx <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (w_acc) begin
                    r_mode <= s_axis_tuser[2:0];
                    r_perflag <= s_axis_tuser[3];
                    r_notflag <= s_axis_tuser[4];
                    r_key <= s_axis_tdata[31:0];
                    r_per <= s_axis_tdata[63:32];
                    r_idx <= CW'(1);
                    r_dv <= 1'b1;
                    r_didx <= '0;
                    r_found <= 1'b0;
                    r_free_ok <= 1'b0;
                    r_pend <= '0;
                    r_pendn <= '0;
                    r_nres <= '0;
                    if (s_axis_tuser[2:0] == mtt_pkg::MODE_TICK) begin
                        r_time <= r_time + 64'd1;
                        r_state <= S_MARK;
                    end else if (s_axis_tuser[2:0] <= mtt_pkg::MODE_QRY) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_used[r_didx] && w_rd.key == r_key && !r_found) begin
                        r_found <= 1'b1;
                        r_fslot <= r_didx;
                    end
                    if (!r_used[r_didx] && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_freeslot <= r_didx;
                    end
                    r_didx <= r_didx + SW'(1);
                    r_idx <= r_idx + CW'(1);
                    if (w_scan_end) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // read back the found slot for a reset-interval rewrite
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (r_mode == mtt_pkg::MODE_ADD && !r_found && r_free_ok)
                        r_used[r_freeslot] <= 1'b1;
                    if (r_mode == mtt_pkg::MODE_DEL && r_found)
                        r_used[r_fslot] <= 1'b0;
                    r_state <= S_IDLE;
                end
                S_MARK: begin
                    if (r_used[r_didx] && w_lt) r_pend[r_didx] <= 1'b1;
                    if (r_used[r_didx] && w_lt && w_rd.notify) r_pendn[r_didx] <= 1'b1;
                    r_didx <= r_didx + SW'(1);
                    r_idx <= r_idx + CW'(1);
                    if (w_scan_end) begin
                        r_state <= S_PICK;
                        r_idx <= CW'(1);
                        r_didx <= '0;
                        r_best_ok <= 1'b0;
                    end
                end
                S_PICK: begin
                    if (r_pend == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        if (r_pend[r_didx] && (!r_best_ok || w_lt)) begin
                            r_best_ok <= 1'b1;
                            r_best <= r_didx;
                            r_best_dl <= w_rd.deadline;
                        end
                        r_didx <= r_didx + SW'(1);
                        r_idx <= r_idx + CW'(1);
                        if (w_scan_end) begin
                            r_state <= S_SERV;
                            r_dv <= 1'b0;
                        end
                    end
                end
                S_SERV: begin
                    if (!r_dv) begin
                        r_dv <= 1'b1;
                    end else begin
                        r_pend[r_best] <= 1'b0;
                        r_pendn[r_best] <= 1'b0;
                        if (!w_rd.periodic) r_used[r_best] <= 1'b0;
                        if (w_push) r_nres <= r_nres + mtt_pkg::ResW'(1);
                        r_state <= S_PICK;
                        r_idx <= CW'(1);
                        r_didx <= '0;
                        r_best_ok <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `MTT_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, s_axis_tready, r_state == S_IDLE)
    `MTT_ASSERT_NXT(a_tick_time, i_clk, i_rst_n, w_acc && s_axis_tuser[2:0] == mtt_pkg::MODE_TICK, r_time == $past(r_time) + 64'd1)
    `MTT_ASSERT_IMP(a_cmd_one, i_clk, i_rst_n, r_state == S_WRITE, w_push && w_pd.last)
endmodule
